FILE: rtl/dcsw_pkg.sv
// shared types, constants and helpers for the dds channel serial writer
// no dependencies; used by every rtl file of the block
`default_nettype none

package dcsw_pkg;

   localparam logic [1:0] KIND_FREQ  = 2'd0;
   localparam logic [1:0] KIND_PHASE = 2'd1;
   localparam logic [1:0] KIND_AMPL  = 2'd2;
   localparam logic [1:0] KIND_NONE  = 2'd3;

   localparam logic [7:0] ADDR_CHSEL = 8'h00;
   localparam logic [7:0] ADDR_FREQ  = 8'h04;
   localparam logic [7:0] ADDR_PHASE = 8'h05;
   localparam logic [7:0] ADDR_AMPL  = 8'h06;
   localparam logic [7:0] CHSEL_BASE = 8'h10;
   localparam logic [15:0] AMPL_ENABLE = 16'h1000;

   // 2^32 / 500e6 == 2^24 / 5^9; below the limit the word is (value * FREQ_RECIP) >> 50
   localparam logic [28:0] FREQ_LIMIT = 29'd500000000;
   localparam logic [53:0] FREQ_RECIP = 54'd9671406556917034;
   localparam logic [26:0] RECIP_LO   = FREQ_RECIP[26:0];
   localparam logic [26:0] RECIP_HI   = FREQ_RECIP[53:27];

   localparam int SHIFT_BITS = 56;
   localparam int CNT_BITS   = 6;
   localparam logic [CNT_BITS-1:0] FRAME1_END   = 6'd15;
   localparam logic [CNT_BITS-1:0] FRAME2_START = 6'd16;
   localparam logic [CNT_BITS-1:0] DIV_LAST     = 6'd1;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  channel;
      logic [28:0] value;
   } req_type;

   typedef struct packed {
      logic data_bit;
      logic frame_start;
      logic frame_end;
      logic update_pulse;
      logic last;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic build;
      logic shift;
   } cmd_type;

   typedef struct packed {
      logic kind_none;
      logic kind_freq;
      logic div_done;
      logic last_bit;
   } stat_type;

   function automatic logic [CNT_BITS-1:0] last_index(input logic [1:0] kind);
      logic [CNT_BITS-1:0] idx;
      unique case (kind)
         KIND_FREQ:  idx = 6'd55;
         KIND_PHASE: idx = 6'd39;
         KIND_AMPL:  idx = 6'd47;
         default:    idx = 6'd55;
      endcase
      return idx;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/dcsw_ctrl.sv
// controller state machine: sequences capture, division, frame build and bit output
// depends on dcsw_pkg
`default_nettype none

module dcsw_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire dcsw_pkg::stat_type stat,
   output dcsw_pkg::cmd_type       cmd,
   output logic                    busy,
   output logic                    rsp_valid
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_DIV   = 4'b0010,
      ST_BUILD = 4'b0100,
      ST_SEND  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && !stat.kind_none) begin
               cmd.load = 1'b1;
               state_in = stat.kind_freq ? ST_DIV : ST_BUILD;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) begin
               state_in = ST_BUILD;
            end
         end
         ST_BUILD: begin
            cmd.build = 1'b1;
            state_in  = ST_SEND;
         end
         ST_SEND: begin
            cmd.shift = 1'b1;
            if (stat.last_bit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_SEND);

endmodule

`default_nettype wire

FILE: rtl/dcsw_dp.sv
// datapath: command capture, reciprocal-multiply tuning word unit, frame shift register
// depends on dcsw_pkg
`default_nettype none

module dcsw_dp (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire dcsw_pkg::req_type req_item,
   input  wire dcsw_pkg::cmd_type cmd,
   output dcsw_pkg::stat_type     stat,
   output dcsw_pkg::rsp_type      rsp_item
);

   logic [1:0]  kind_ff;
   logic [1:0]  chan_ff;
   logic [28:0] val_ff;
   logic        sat_ff;
   logic [55:0] plo_ff, plo_in;
   logic [55:0] phi_ff, phi_in;
   logic [31:0] num_ff, num_in;
   logic [dcsw_pkg::SHIFT_BITS-1:0] sh_ff, sh_in;
   logic [dcsw_pkg::CNT_BITS-1:0]   cnt_ff, cnt_in;

   logic [56:0] prod_sum;
   logic [31:0] tuning_word;
   logic [15:0] ampl_word;
   logic [7:0]  sel_byte;
   logic [dcsw_pkg::CNT_BITS-1:0] last_idx;

   // upper part of value * reciprocal, low 27 bits of the sum come from plo alone
   assign prod_sum = {1'b0, phi_ff} + {28'd0, plo_ff[55:27]};

   assign tuning_word = sat_ff ? 32'hFFFF_FFFF : num_ff;
   assign ampl_word   = val_ff[15:0] | dcsw_pkg::AMPL_ENABLE;
   assign sel_byte    = dcsw_pkg::CHSEL_BASE << chan_ff;
   assign last_idx    = dcsw_pkg::last_index(kind_ff);

   always_comb begin
      plo_in = plo_ff;
      phi_in = phi_ff;
      num_in = num_ff;
      sh_in  = sh_ff;
      cnt_in = cnt_ff;
      if (cmd.load) begin
         cnt_in = '0;
      end else if (cmd.div_step) begin
         if (cnt_ff == '0) begin
            plo_in = 56'(val_ff) * 56'(dcsw_pkg::RECIP_LO);
            phi_in = 56'(val_ff) * 56'(dcsw_pkg::RECIP_HI);
         end else begin
            num_in = prod_sum[54:23];
         end
         cnt_in = cnt_ff + 6'd1;
      end else if (cmd.build) begin
         cnt_in = '0;
         case (kind_ff)
            dcsw_pkg::KIND_PHASE:
               sh_in = {dcsw_pkg::ADDR_CHSEL, sel_byte, dcsw_pkg::ADDR_PHASE,
                        val_ff[15:0], 16'd0};
            dcsw_pkg::KIND_AMPL:
               sh_in = {dcsw_pkg::ADDR_CHSEL, sel_byte, dcsw_pkg::ADDR_AMPL,
                        8'd0, ampl_word, 8'd0};
            default:
               sh_in = {dcsw_pkg::ADDR_CHSEL, sel_byte, dcsw_pkg::ADDR_FREQ,
                        tuning_word};
         endcase
      end else if (cmd.shift) begin
         sh_in  = {sh_ff[dcsw_pkg::SHIFT_BITS-2:0], 1'b0};
         cnt_in = cnt_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      plo_ff <= plo_in;
      phi_ff <= phi_in;
      num_ff <= num_in;
      sh_ff  <= sh_in;
      if (cmd.load) begin
         kind_ff <= req_item.kind;
         chan_ff <= req_item.channel;
         val_ff  <= req_item.value;
         sat_ff  <= (req_item.value >= dcsw_pkg::FREQ_LIMIT);
      end
   end

   assign stat.kind_none = (req_item.kind == dcsw_pkg::KIND_NONE);
   assign stat.kind_freq = (req_item.kind == dcsw_pkg::KIND_FREQ);
   assign stat.div_done  = (cnt_ff == dcsw_pkg::DIV_LAST);
   assign stat.last_bit  = (cnt_ff == last_idx);

   assign rsp_item.data_bit     = sh_ff[dcsw_pkg::SHIFT_BITS-1];
   assign rsp_item.frame_start  = (cnt_ff == '0) || (cnt_ff == dcsw_pkg::FRAME2_START);
   assign rsp_item.frame_end    = (cnt_ff == dcsw_pkg::FRAME1_END) || (cnt_ff == last_idx);
   assign rsp_item.update_pulse = rsp_item.frame_end && (kind_ff != dcsw_pkg::KIND_PHASE);
   assign rsp_item.last         = (cnt_ff == last_idx);

endmodule

`default_nettype wire

FILE: rtl/dds_channel_spi_writer.sv
// top level of the dds channel serial writer: controller plus datapath
// depends on dcsw_pkg, dcsw_ctrl, dcsw_dp
//
// usage:
//   a command transaction (kind, channel, value on req_item) is taken at a rising
//   edge with start high and busy low. kind 3 is dropped and leaves busy low.
//   the block then emits one serial bit per cycle on rsp_item, marked by
//   rsp_valid: a 16-bit channel-select frame followed by a 24, 32 or 40-bit
//   register frame, MSB first, with frame start/end, update and last marks.
//   phase and amplitude: the build state, then the 40 or 48 frame bits.
//   frequency: the tuning word unit (split reciprocal multiply, then the sum),
//   then the build state, then the 56 frame bits.
//   busy drops the cycle after the last bit, so a new command can be taken then.
//   the bit stream is continuous inside a command; the receiver takes each
//   bit in its cycle and cannot hold the stream off.
//   reset returns the controller to idle and drops any command in flight.
`default_nettype none

module dds_channel_spi_writer (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire dcsw_pkg::req_type req_item,
   output logic                   rsp_valid,
   output dcsw_pkg::rsp_type      rsp_item
);

   dcsw_pkg::cmd_type  cmd;
   dcsw_pkg::stat_type stat;

   dcsw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   dcsw_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_item (rsp_item)
   );

endmodule

`default_nettype wire

FILE: rtl/dcsw_checker.sv
// port-level checks on the serial bit stream of the writer, bound to the top level
// depends on dcsw_pkg and dds_channel_spi_writer
`default_nettype none

module dcsw_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire dcsw_pkg::req_type req_item,
   input wire logic              rsp_valid,
   input wire dcsw_pkg::rsp_type rsp_item
);

   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("bit strobed while not busy");

   a_stream_gapless: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.last |=> rsp_valid)
      else $error("gap inside a command bit stream");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.last |=> !rsp_valid && !busy)
      else $error("stream continues after last bit");

   a_frames_abut: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.frame_end && !rsp_item.last |=> rsp_item.frame_start)
      else $error("second frame does not follow first frame end");

   a_update_on_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.frame_end |-> !rsp_item.update_pulse)
      else $error("update mark away from frame end");

endmodule

bind dds_channel_spi_writer dcsw_checker u_checker (.*);

`default_nettype wire
